@@ src/fhc_pkg.sv @@
// Shared types, constants and the bytewise CRC-32 update for the frame header checker.
package fhc_pkg;

	localparam int unsigned DATA_W   = 32;
	localparam int unsigned STATUS_W = 2;
	localparam logic [DATA_W-1:0] HDR_LEN  = 32'd20;
	localparam logic [DATA_W-1:0] CNT_MAX  = 32'hFFFF_FFFF;
	localparam logic [DATA_W-1:0] CRC_POLY = 32'hEDB8_8320;
	localparam logic [DATA_W-1:0] CRC_INIT = 32'hFFFF_FFFF;

	// Header byte offsets where each region starts
	localparam logic [DATA_W-1:0] OFS_FORMAT    = 32'd4;
	localparam logic [DATA_W-1:0] OFS_ALGORITHM = 32'd8;
	localparam logic [DATA_W-1:0] OFS_LENGTH    = 32'd12;
	localparam logic [DATA_W-1:0] OFS_CRC       = 32'd16;

	localparam logic [7:0] MAGIC [4] = '{8'h42, 8'h56, 8'h49, 8'h53};

	localparam logic [DATA_W-1:0] RST_FORMAT    = 32'd1;
	localparam logic [DATA_W-1:0] RST_ALGORITHM = 32'd1;
	localparam logic [DATA_W-1:0] RST_MAX_FRAME = 32'd67108864;

	typedef enum logic [1:0] {
		CFG_FORMAT    = 2'd0,
		CFG_ALGORITHM = 2'd1,
		CFG_MAX_FRAME = 2'd2
	} cfg_index_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK         = 2'd0,
		ST_BAD_SIZE   = 2'd1,
		ST_BAD_HEADER = 2'd2,
		ST_MISMATCH   = 2'd3
	} status_t;

	// Frame state at the last byte, handed to the verdict stage
	typedef struct packed {
		logic [DATA_W-1:0] total;
		logic              header_ok;
		logic [DATA_W-1:0] length_field;
		logic [DATA_W-1:0] crc_field;
		logic [DATA_W-1:0] crc;
	} summary_t;

	function automatic logic [DATA_W-1:0] crc_byte(input logic [DATA_W-1:0] crc,
		input logic [7:0] b);
		logic [DATA_W-1:0] c;
		c = crc ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			c = (c >> 1) ^ (c[0] ? CRC_POLY : '0);
		end
		return c;
	endfunction

endpackage

@@ src/frame_header_crc_checker_top.sv @@
// Top level of the frame header checker: configuration registers and the two stages.
// A final byte passes the input register, the summary register and the output word register on its way to m_tdata.
// Throughput: one byte per cycle; the byte stream stalls only when the final byte of a
//   frame finds both the summary register and the output register still occupied.
// Reset: arst_n clears the frame state and the word valids, and loads the configuration
//   registers with format and algorithm version 1 and a size limit of 64 MiB.
module frame_header_crc_checker_top
	import fhc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tlast,   // last_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [1:0] status, [33:2] computed_crc, [39:34] zero
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	logic [DATA_W-1:0]   format_q;
	logic [DATA_W-1:0]   algorithm_q;
	logic [DATA_W-1:0]   max_frame_q;
	logic                sum_valid;
	logic                sum_ready;
	summary_t            sum;
	logic [STATUS_W-1:0] status;
	logic [DATA_W-1:0]   crc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			format_q    <= RST_FORMAT;
			algorithm_q <= RST_ALGORITHM;
			max_frame_q <= RST_MAX_FRAME;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_FORMAT:    format_q    <= cfg_data;
				CFG_ALGORITHM: algorithm_q <= cfg_data;
				CFG_MAX_FRAME: max_frame_q <= cfg_data;
				default: ;
			endcase
		end
	end

	fhc_frame u_frame (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_byte   (s_tdata),
		.in_last   (s_tlast),
		.fmt_word  (format_q),
		.alg_word  (algorithm_q),
		.sum_valid (sum_valid),
		.sum_ready (sum_ready),
		.sum       (sum)
	);

	fhc_verdict u_verdict (
		.clk             (clk),
		.arst_n          (arst_n),
		.sum_valid       (sum_valid),
		.sum_ready       (sum_ready),
		.sum             (sum),
		.max_frame_bytes (max_frame_q),
		.out_valid       (m_tvalid),
		.out_ready       (m_tready),
		.out_status      (status),
		.out_crc         (crc)
	);

	assign m_tdata = {6'd0, crc, status};

endmodule

@@ src/fhc_frame.sv @@
// Input register and per-frame state: byte count, header compare, field capture, running CRC.
module fhc_frame
	import fhc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        in_byte,
	input  logic              in_last,
	input  logic [DATA_W-1:0] fmt_word,
	input  logic [DATA_W-1:0] alg_word,
	output logic              sum_valid,
	input  logic              sum_ready,
	output summary_t          sum
);

	logic              v_s1;
	logic [7:0]        data_s1;
	logic              last_s1;
	logic              adv;

	logic [DATA_W-1:0] cnt_q;
	logic [DATA_W-1:0] crc_q;
	logic              match_q;
	logic [DATA_W-1:0] len_q;
	logic [DATA_W-1:0] crcf_q;

	logic [DATA_W-1:0] cnt_d;
	logic [DATA_W-1:0] crc_d;
	logic              match_d;
	logic [DATA_W-1:0] len_d;
	logic [DATA_W-1:0] crcf_d;
	logic [7:0]        expect_byte;
	logic [1:0]        lane;

	// Non-final words never wait; the final one waits for the verdict stage
	assign adv      = v_s1 && (!last_s1 || sum_ready);
	assign in_ready = !v_s1 || adv;
	assign lane     = cnt_q[1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			v_s1 <= 1'b1;
		end else if (adv) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1 <= in_byte;
			last_s1 <= in_last;
		end
	end

	always_comb begin
		if (cnt_q < OFS_FORMAT) begin
			expect_byte = MAGIC[lane];
		end else if (cnt_q < OFS_ALGORITHM) begin
			expect_byte = fmt_word[{lane, 3'b000} +: 8];
		end else begin
			expect_byte = alg_word[{lane, 3'b000} +: 8];
		end
	end

	always_comb begin
		match_d = match_q;
		len_d   = len_q;
		crcf_d  = crcf_q;
		crc_d   = crc_q;
		if (cnt_q < OFS_LENGTH) begin
			if (data_s1 != expect_byte) begin
				match_d = 1'b0;
			end
		end else if (cnt_q < OFS_CRC) begin
			len_d[{lane, 3'b000} +: 8] = data_s1;
		end else if (cnt_q < HDR_LEN) begin
			crcf_d[{lane, 3'b000} +: 8] = data_s1;
		end else begin
			crc_d = crc_byte(crc_q, data_s1);
		end
		cnt_d = (cnt_q == CNT_MAX) ? cnt_q : cnt_q + 32'd1;
	end

	// Drop back to the cleared frame state once the final word leaves
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			crc_q   <= CRC_INIT;
			match_q <= 1'b1;
			len_q   <= '0;
			crcf_q  <= '0;
		end else if (adv) begin
			if (last_s1) begin
				cnt_q   <= '0;
				crc_q   <= CRC_INIT;
				match_q <= 1'b1;
				len_q   <= '0;
				crcf_q  <= '0;
			end else begin
				cnt_q   <= cnt_d;
				crc_q   <= crc_d;
				match_q <= match_d;
				len_q   <= len_d;
				crcf_q  <= crcf_d;
			end
		end
	end

	assign sum_valid        = v_s1 && last_s1;
	assign sum.total        = cnt_d;
	assign sum.header_ok    = match_d;
	assign sum.length_field = len_d;
	assign sum.crc_field    = crcf_d;
	assign sum.crc          = crc_d;

endmodule

@@ src/fhc_verdict.sv @@
// Summary register, status decision and the output word register.
module fhc_verdict
	import fhc_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                sum_valid,
	output logic                sum_ready,
	input  summary_t            sum,
	input  logic [DATA_W-1:0]   max_frame_bytes,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [STATUS_W-1:0] out_status,
	output logic [DATA_W-1:0]   out_crc
);

	logic              v_s2;
	summary_t          sum_s2;
	logic              adv;
	logic              out_valid_q;
	status_t           status_q;
	logic [DATA_W-1:0] crc_q;
	status_t           status_d;
	logic [DATA_W-1:0] computed;

	assign adv       = v_s2 && (!out_valid_q || out_ready);
	assign sum_ready = !v_s2 || adv;
	assign computed  = ~sum_s2.crc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (sum_valid && sum_ready) begin
			v_s2 <= 1'b1;
		end else if (adv) begin
			v_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (sum_valid && sum_ready) begin
			sum_s2 <= sum;
		end
	end

	always_comb begin
		if (sum_s2.total < HDR_LEN || sum_s2.total > max_frame_bytes) begin
			status_d = ST_BAD_SIZE;
		end else if (!sum_s2.header_ok) begin
			status_d = ST_BAD_HEADER;
		end else if (sum_s2.length_field != sum_s2.total - HDR_LEN ||
			sum_s2.crc_field != computed) begin
			status_d = ST_MISMATCH;
		end else begin
			status_d = ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			status_q <= status_d;
			crc_q    <= computed;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_status = status_q;
	assign out_crc    = crc_q;

endmodule

@@ src/fhc_checker.sv @@
// Port-level checker for the frame header checker, bound to the top level.
module fhc_checker
	import fhc_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        s_tlast,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata
);

	logic       last_in;
	logic       word_out;
	logic [1:0] pending_q;

	assign last_in  = s_tvalid && s_tready && s_tlast;
	assign word_out = m_tvalid && m_tready;

	// Final bytes taken whose status word has not yet gone out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (last_in && !word_out) begin
			pending_q <= pending_q + 2'd1;
		end else if (word_out && !last_in) begin
			pending_q <= pending_q - 2'd1;
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("status word changed while stalled");

	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> pending_q != 2'd0)
		else $error("status word without a final byte");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> pending_q != 2'd0)
		else $error("input stalled with no frame outstanding");

	a_capacity: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q == 2'd3 |-> !s_tready || !s_tvalid || !s_tlast || word_out)
		else $error("more final bytes taken than the block can hold");

	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[39:34] == 6'd0)
		else $error("padding bits set");

endmodule

bind frame_header_crc_checker_top fhc_checker u_fhc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tlast  (s_tlast),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

@@ sim/frame_header_crc_checker_top_test.sv @@
// Self-checking testbench for the frame header checker: byte stream in, status words out.
module frame_header_crc_checker_top_test;
	import fhc_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 8;
	localparam int RANDOM_BYTES = 1470;
	localparam int PHASE_BYTES  = 300;

	// Header fields that a frame can carry corrupted
	localparam logic [4:0] F_NONE   = 5'b00000;
	localparam logic [4:0] F_MAGIC  = 5'b00001;
	localparam logic [4:0] F_FORMAT = 5'b00010;
	localparam logic [4:0] F_ALGO   = 5'b00100;
	localparam logic [4:0] F_LENGTH = 5'b01000;
	localparam logic [4:0] F_CRC    = 5'b10000;

	typedef enum logic [1:0] {
		FILL_RANDOM = 2'd0,
		FILL_ZERO   = 2'd1,
		FILL_ONES   = 2'd2,
		FILL_NOISE  = 2'd3
	} fill_t;

	typedef struct packed {
		logic [15:0] payload;
		logic [15:0] cut;
		logic [4:0]  faults;
		fill_t       fill;
		logic [31:0] max_bytes;
		logic        st_typed;
		status_t     st;
		logic        crc_zero;
	} frame_row_t;

	typedef struct {
		status_t     status;
		logic [31:0] crc;
	} verdict_t;

	typedef logic [7:0] frame_q_t [$];

	localparam int PLAN_ROWS = 19;
	localparam frame_row_t PLAN [PLAN_ROWS] = '{
		'{16'd0, 16'd0,  F_NONE,           FILL_RANDOM, RST_MAX_FRAME, 1'b1, ST_OK,         1'b1},
		'{16'd1, 16'd0,  F_NONE,           FILL_ZERO,   RST_MAX_FRAME, 1'b0, ST_OK,         1'b0},
		'{16'd8, 16'd0,  F_NONE,           FILL_ONES,   RST_MAX_FRAME, 1'b0, ST_OK,         1'b0},
		'{16'd5, 16'd0,  F_NONE,           FILL_RANDOM, RST_MAX_FRAME, 1'b0, ST_OK,         1'b0},
		'{16'd0, 16'd1,  F_NONE,           FILL_RANDOM, RST_MAX_FRAME, 1'b1, ST_BAD_SIZE,   1'b1},
		'{16'd0, 16'd19, F_NONE,           FILL_RANDOM, RST_MAX_FRAME, 1'b1, ST_BAD_SIZE,   1'b1},
		'{16'd3, 16'd0,  F_MAGIC,          FILL_RANDOM, RST_MAX_FRAME, 1'b1, ST_BAD_HEADER, 1'b0},
		'{16'd3, 16'd0,  F_FORMAT,         FILL_RANDOM, RST_MAX_FRAME, 1'b1, ST_BAD_HEADER, 1'b0},
		'{16'd3, 16'd0,  F_ALGO,           FILL_RANDOM, RST_MAX_FRAME, 1'b1, ST_BAD_HEADER, 1'b0},
		'{16'd4, 16'd0,  F_LENGTH,         FILL_RANDOM, RST_MAX_FRAME, 1'b1, ST_MISMATCH,   1'b0},
		'{16'd4, 16'd0,  F_CRC,            FILL_RANDOM, RST_MAX_FRAME, 1'b1, ST_MISMATCH,   1'b0},
		'{16'd2, 16'd0,  F_FORMAT | F_CRC, FILL_RANDOM, RST_MAX_FRAME, 1'b1, ST_BAD_HEADER, 1'b0},
		'{16'd2, 16'd10, F_MAGIC,          FILL_RANDOM, RST_MAX_FRAME, 1'b1, ST_BAD_SIZE,   1'b1},
		'{16'd6, 16'd0,  F_NONE,           FILL_NOISE,  RST_MAX_FRAME, 1'b0, ST_OK,         1'b0},
		'{16'd0, 16'd0,  F_NONE,           FILL_RANDOM, 32'd20,        1'b1, ST_OK,         1'b1},
		'{16'd1, 16'd0,  F_MAGIC,          FILL_RANDOM, 32'd20,        1'b1, ST_BAD_SIZE,   1'b0},
		'{16'd0, 16'd0,  F_NONE,           FILL_RANDOM, 32'd19,        1'b1, ST_BAD_SIZE,   1'b1},
		'{16'd0, 16'd5,  F_NONE,           FILL_RANDOM, 32'd0,         1'b1, ST_BAD_SIZE,   1'b1},
		'{16'd9, 16'd0,  F_NONE,           FILL_ONES,   32'hFFFF_FFFF, 1'b0, ST_OK,         1'b0}
	};

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata   = 8'd0;   // [7:0] data_byte
	logic        s_tlast   = 1'b0;   // last_byte
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [39:0] m_tdata;            // [1:0] status, [33:2] computed_crc, [39:34] zero
	logic        cfg_we    = 1'b0;
	logic [1:0]  cfg_index = 2'd0;
	logic [31:0] cfg_data  = 32'd0;

	// Configuration as the block should hold it
	logic [31:0] want_format = RST_FORMAT;
	logic [31:0] want_algo   = RST_ALGORITHM;
	logic [31:0] size_limit  = RST_MAX_FRAME;

	// Frame state as the block should hold it
	logic [31:0] fr_count    = 32'd0;
	logic [31:0] fr_crc      = CRC_INIT;
	logic        fr_hdr_ok   = 1'b1;
	logic [31:0] fr_len_word = 32'd0;
	logic [31:0] fr_crc_word = 32'd0;

	verdict_t pending_verdicts [$];
	verdict_t head;

	bit src_idle  = 1'b1;
	bit sink_idle = 1'b1;
	int sink_stall;
	int cycle_count;
	int mismatches;
	int statuses_seen;
	int frames_sent;
	int bytes_sent;
	int settings_used;

	frame_header_crc_checker_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #4 clk = ~clk;

	function automatic logic [31:0] crc32_step(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

	// Advance the expected frame state by one accepted byte; give the status on the last one
	function automatic void track_byte(input logic [7:0] b, input logic last, output verdict_t v);
		logic [31:0] pos;
		logic [31:0] computed;
		pos = fr_count;
		v.status = ST_OK;
		v.crc = 32'd0;
		if (pos < OFS_FORMAT) begin
			if (b != MAGIC[pos[1:0]]) fr_hdr_ok = 1'b0;
		end else if (pos < OFS_ALGORITHM) begin
			if (b != want_format[8*(pos-OFS_FORMAT) +: 8]) fr_hdr_ok = 1'b0;
		end else if (pos < OFS_LENGTH) begin
			if (b != want_algo[8*(pos-OFS_ALGORITHM) +: 8]) fr_hdr_ok = 1'b0;
		end else if (pos < OFS_CRC) begin
			fr_len_word[8*(pos-OFS_LENGTH) +: 8] = b;
		end else if (pos < HDR_LEN) begin
			fr_crc_word[8*(pos-OFS_CRC) +: 8] = b;
		end else begin
			fr_crc = crc32_step(fr_crc, b);
		end
		if (fr_count != CNT_MAX) fr_count = fr_count + 32'd1;
		if (last) begin
			computed = ~fr_crc;
			v.crc = computed;
			if (fr_count < HDR_LEN || fr_count > size_limit) begin
				v.status = ST_BAD_SIZE;
			end else if (!fr_hdr_ok) begin
				v.status = ST_BAD_HEADER;
			end else if (fr_len_word != fr_count - HDR_LEN || fr_crc_word != computed) begin
				v.status = ST_MISMATCH;
			end else begin
				v.status = ST_OK;
			end
			fr_count = 32'd0;
			fr_crc = CRC_INIT;
			fr_hdr_ok = 1'b1;
			fr_len_word = 32'd0;
			fr_crc_word = 32'd0;
		end
	endfunction

	// Assemble a well-formed frame for the current configuration, then spoil it as asked
	function automatic void build_frame(input int payload, input int cut, input logic [4:0] faults,
		input fill_t fill, output frame_q_t q);
		logic [7:0]  body [$];
		logic [31:0] c;
		logic [7:0]  b;
		logic [31:0] len_word;
		q = {};
		c = CRC_INIT;
		for (int k = 0; k < payload; k++) begin
			case (fill)
				FILL_ZERO: b = 8'h00;
				FILL_ONES: b = 8'hFF;
				default:   b = 8'($urandom);
			endcase
			body = {body, b};
			c = crc32_step(c, b);
		end
		c = ~c;
		len_word = 32'(payload);
		for (int k = 0; k < 4; k++) q = {q, MAGIC[k]};
		for (int k = 0; k < 4; k++) q = {q, want_format[8*k +: 8]};
		for (int k = 0; k < 4; k++) q = {q, want_algo[8*k +: 8]};
		for (int k = 0; k < 4; k++) q = {q, len_word[8*k +: 8]};
		for (int k = 0; k < 4; k++) q = {q, c[8*k +: 8]};
		q = {q, body};
		if (fill == FILL_NOISE) begin
			foreach (q[k]) q[k] = 8'($urandom);
		end
		if ((faults & F_MAGIC) != 0)  q[$urandom_range(0, 3)]  ^= 8'($urandom_range(1, 255));
		if ((faults & F_FORMAT) != 0) q[$urandom_range(4, 7)]  ^= 8'($urandom_range(1, 255));
		if ((faults & F_ALGO) != 0)   q[$urandom_range(8, 11)] ^= 8'($urandom_range(1, 255));
		if ((faults & F_LENGTH) != 0) q[$urandom_range(12, 15)] ^= 8'($urandom_range(1, 255));
		if ((faults & F_CRC) != 0)    q[$urandom_range(16, 19)] ^= 8'($urandom_range(1, 255));
		if (cut > 0) begin
			while (q.size() > cut) void'(q.pop_back());
		end
	endfunction

	function automatic logic [31:0] pick_version();
		case ($urandom_range(0, 5))
			0:       return 32'd0;
			1:       return 32'hFFFF_FFFF;
			2:       return 32'd1;
			default: return 32'($urandom);
		endcase
	endfunction

	function automatic logic [31:0] pick_limit();
		case ($urandom_range(0, 9))
			0:       return 32'd0;
			1:       return 32'd19;
			2:       return 32'd20;
			3:       return 32'hFFFF_FFFF;
			4, 5, 6: return 32'd20 + 32'($urandom_range(0, 60));
			default: return 32'($urandom) | 32'h0000_1000;
		endcase
	endfunction

	task automatic put_byte(input logic [7:0] b, input logic last, output verdict_t v);
		if (src_idle && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		track_byte(b, last, v);
	endtask

	task automatic send_frame(input frame_q_t q, input logic typed, input status_t st,
		input logic crc_zero);
		verdict_t v;
		for (int k = 0; k < q.size(); k++) begin
			put_byte(q[k], k == q.size() - 1, v);
		end
		// Rows with a status read straight off the header take it as typed
		if (typed) v.status = st;
		if (crc_zero) v.crc = 32'd0;
		pending_verdicts = {pending_verdicts, v};
		frames_sent++;
		bytes_sent += q.size();
	endtask

	// Hold the stream until every status is out and the pipeline has emptied
	task automatic drain_stream();
		s_tvalid <= 1'b0;
		while (pending_verdicts.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_index_t idx, input logic [31:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
	endtask

	task automatic load_config(input logic [2:0] sel, input logic [31:0] fmt,
		input logic [31:0] alg, input logic [31:0] lim);
		if (sel[CFG_FORMAT]) begin
			write_reg(CFG_FORMAT, fmt);
			want_format = fmt;
		end
		if (sel[CFG_ALGORITHM]) begin
			write_reg(CFG_ALGORITHM, alg);
			want_algo = alg;
		end
		if (sel[CFG_MAX_FRAME]) begin
			write_reg(CFG_MAX_FRAME, lim);
			size_limit = lim;
		end
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	// Receiver: while sink_idle is set, stall at random, holding m_tready low for a burst
	always @(posedge clk) begin
		if (sink_stall > 0) begin
			m_tready   <= 1'b0;
			sink_stall <= sink_stall - 1;
		end else if (sink_idle && $urandom_range(0, 5) == 0) begin
			m_tready   <= 1'b0;
			sink_stall <= $urandom_range(0, 3);
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			statuses_seen++;
			if (pending_verdicts.size() == 0) begin
				$display("%0t: status word with none expected: expected nothing, actual %h",
					$time, m_tdata);
				mismatches++;
			end else begin
				head = pending_verdicts.pop_front();
				if (m_tdata[1:0] !== head.status) begin
					$display("%0t: status expected %0d, actual %0d", $time, head.status,
						m_tdata[1:0]);
					mismatches++;
				end
				if (m_tdata[33:2] !== head.crc) begin
					$display("%0t: computed_crc expected %h, actual %h", $time, head.crc,
						m_tdata[33:2]);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: cycle limit reached with %0d statuses outstanding", $time,
				pending_verdicts.size());
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		frame_q_t    frame;
		frame_row_t  row;
		int          random_bytes;
		int          phase_start;
		int          payload;
		int          cut;
		logic [4:0]  faults;
		fill_t       fill;
		random_bytes = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < PLAN_ROWS; r++) begin
			row = PLAN[r];
			if (row.max_bytes != size_limit) begin
				drain_stream();
				load_config(3'b100, want_format, want_algo, row.max_bytes);
			end
			build_frame(int'(row.payload), int'(row.cut), row.faults, row.fill, frame);
			send_frame(frame, row.st_typed, row.st, row.crc_zero);
		end

		while (random_bytes < RANDOM_BYTES) begin
			drain_stream();
			load_config(3'b111, pick_version(), pick_version(), pick_limit());
			// Leave the closing stretch free of gaps on both sides
			if (random_bytes >= RANDOM_BYTES - PHASE_BYTES) begin
				src_idle  = 1'b0;
				sink_idle = 1'b0;
			end else begin
				src_idle  = $urandom_range(0, 3) != 0;
				sink_idle = $urandom_range(0, 3) != 0;
			end
			phase_start = random_bytes;
			while (random_bytes - phase_start < PHASE_BYTES && random_bytes < RANDOM_BYTES) begin
				if ($urandom_range(0, 9) == 0) begin
					payload = $urandom_range(100, 300);
				end else begin
					payload = $urandom_range(0, 40);
				end
				faults = F_NONE;
				cut = 0;
				fill = FILL_RANDOM;
				case ($urandom_range(0, 9))
					5:       fill = ($urandom_range(0, 1) != 0) ? FILL_ZERO : FILL_ONES;
					6:       faults = 5'(1 << $urandom_range(0, 4));
					7:       faults = 5'($urandom_range(1, 31));
					8:       cut = $urandom_range(1, payload + 19);
					9:       fill = FILL_NOISE;
					default: ;
				endcase
				build_frame(payload, cut, faults, fill, frame);
				random_bytes += frame.size();
				send_frame(frame, 1'b0, ST_OK, 1'b0);
			end
		end

		s_tvalid <= 1'b0;
		while (pending_verdicts.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d bytes in %0d frames under %0d register settings;", bytes_sent,
			frames_sent, settings_used);
		$display("checked %0d status words, %0d mismatches.", statuses_seen, mismatches);
		if (mismatches == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
